// ===== rtl/integer_table_insert_search_delete_sort_top_defines.svh =====
// assertion macros for the integer table block
// used by the top level only; expects clk and rst in scope
`ifndef INTEGER_TABLE_INSERT_SEARCH_DELETE_SORT_TOP_DEFINES_SVH
`define INTEGER_TABLE_INSERT_SEARCH_DELETE_SORT_TOP_DEFINES_SVH

// same-cycle implication
`define ITSDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ITSDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/itsds_pkg.sv =====
// shared types and constants for the integer table block
// no dependencies
package itsds_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int ECNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_SORT   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_COMPARE,
    CMD_DELETE,
    CMD_SORT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [DATA_W-1:0]  key;
    logic [CNT_W-1:0]          count;
    logic                      phase;
    logic [IDX_W-1:0]          del_idx;
    logic signed [DATA_W-1:0]  last_value;
  } cell_ctrl_t;

endpackage

// ===== rtl/itsds_if.sv =====
// request and response channel interfaces, valid/ready handshake
// depends on itsds_pkg
interface itsds_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [itsds_pkg::FUNC_W-1:0]             func;
  logic signed [itsds_pkg::DATA_W-1:0]      operand_value;

  modport source (output valid, output func, output operand_value, input ready);
  modport sink   (input valid, input func, input operand_value, output ready);
endinterface

interface itsds_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [itsds_pkg::STAT_W-1:0]  status;
  logic [itsds_pkg::POS_W-1:0]   position;
  logic [itsds_pkg::ECNT_W-1:0]  entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

// ===== rtl/itsds_cell.sv =====
// one table slot: holds an entry, compares it with the key, and does
// compare-exchange with its neighbors during sort; depends on itsds_pkg
module itsds_cell (
  input  logic                                 clk,
  input  logic [itsds_pkg::IDX_W-1:0]          idx,
  input  itsds_pkg::cell_ctrl_t                ctrl,
  input  logic signed [itsds_pkg::DATA_W-1:0]  left_value,
  input  logic signed [itsds_pkg::DATA_W-1:0]  right_value,
  input  logic                                 right_swap,
  output logic signed [itsds_pkg::DATA_W-1:0]  value,
  output logic                                 match,
  output logic                                 swap
);
  import itsds_pkg::*;

  logic                      in_use;
  logic signed [DATA_W-1:0]  value_next;

  assign in_use = CNT_W'(idx) < ctrl.count;

  // this cell is the right half of an active pair and holds the smaller value
  assign swap = (ctrl.cmd == CMD_SORT) && (idx != '0) && in_use &&
                (idx[0] != ctrl.phase) && (value < left_value);

  always_comb begin
    value_next = value;
    unique case (ctrl.cmd)
      CMD_INSERT: begin
        if (CNT_W'(idx) == ctrl.count) value_next = ctrl.key;
      end
      CMD_DELETE: begin
        if (idx == ctrl.del_idx) value_next = ctrl.last_value;
      end
      CMD_SORT: begin
        if (swap) value_next = left_value;
        else if (right_swap) value_next = right_value;
      end
      CMD_HOLD, CMD_COMPARE: value_next = value;
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (ctrl.cmd == CMD_COMPARE) match <= in_use && (value == ctrl.key);
  end

endmodule

// ===== rtl/integer_table_insert_search_delete_sort_top.sv =====
// packed table of 16 signed entries as a row of cells; insert goes through
// S_INSERT to S_EMIT (straight to S_EMIT when full), search and delete through
// S_COMPARE and S_PICK, and sort runs odd-even transposition passes along the row.
// one request at a time; the next is taken once the result is in the output
// register, which waits while an earlier result is still held by the receiver.
// synchronous reset empties the table; entry contents are not cleared
module integer_table_insert_search_delete_sort_top (
  input  logic         clk,
  input  logic         rst,
  itsds_req_if.sink    req,
  itsds_rsp_if.source  rsp
);
  import itsds_pkg::*;
  `include "integer_table_insert_search_delete_sort_top_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_COMPARE,
    S_PICK,
    S_SORT,
    S_EMIT
  } state_t;

  state_t                    state;
  op_t                       op;
  logic signed [DATA_W-1:0]  key;
  logic [CNT_W-1:0]          count;
  logic [IDX_W-1:0]          sort_cnt;
  status_t                   res_status;
  logic [POS_W-1:0]          res_pos;

  logic                      rsp_valid;
  status_t                   rsp_status;
  logic [POS_W-1:0]          rsp_position;
  logic [ECNT_W-1:0]         rsp_count;

  cell_ctrl_t                ctrl;
  logic signed [DATA_W-1:0]  cell_value [DEPTH];
  logic [DEPTH-1:0]          match;
  logic [DEPTH-1:0]          swap;
  logic [IDX_W-1:0]          hit_idx;
  logic                      found;
  logic signed [DATA_W-1:0]  last_value;
  logic                      del_hit;
  logic                      search_done;

  // lowest matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
    end
  end
  assign found = |match;

  // last entry in use, moved into the hole on delete
  always_comb begin
    last_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i) == count - CNT_W'(1)) last_value = cell_value[i];
    end
  end

  always_comb begin
    ctrl.key        = key;
    ctrl.count      = count;
    ctrl.phase      = sort_cnt[0];
    ctrl.del_idx    = hit_idx;
    ctrl.last_value = last_value;
    unique case (state)
      S_INSERT:  ctrl.cmd = CMD_INSERT;
      S_COMPARE: ctrl.cmd = CMD_COMPARE;
      S_PICK:    ctrl.cmd = (op == OP_DELETE && found) ? CMD_DELETE : CMD_HOLD;
      S_SORT:    ctrl.cmd = CMD_SORT;
      S_IDLE, S_EMIT: ctrl.cmd = CMD_HOLD;
      default:   ctrl.cmd = CMD_HOLD;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    logic                     right_s;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = '0;
      assign right_s = 1'b0;
    end else begin : g_right
      assign right_v = cell_value[g+1];
      assign right_s = swap[g+1];
    end
    itsds_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(g)),
      .ctrl        (ctrl),
      .left_value  (left_v),
      .right_value (right_v),
      .right_swap  (right_s),
      .value       (cell_value[g]),
      .match       (match[g]),
      .swap        (swap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sort_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the emit state handles its own output register
      if (rsp_valid && rsp.ready && state != S_EMIT) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op  <= op_t'(req.func);
            key <= req.operand_value;
            unique case (op_t'(req.func))
              OP_INSERT: begin
                if (count == CNT_W'(DEPTH)) begin
                  res_status <= ST_FULL;
                  res_pos    <= '0;
                  state      <= S_EMIT;
                end else begin
                  state <= S_INSERT;
                end
              end
              OP_SEARCH, OP_DELETE: state <= S_COMPARE;
              OP_SORT:              state <= S_SORT;
              default:              state <= S_IDLE;
            endcase
          end
        end
        S_INSERT: begin
          res_status <= ST_DONE;
          res_pos    <= POS_W'(count);
          count      <= count + CNT_W'(1);
          state      <= S_EMIT;
        end
        S_COMPARE: state <= S_PICK;
        S_PICK: begin
          if (found) begin
            res_status <= ST_DONE;
            res_pos    <= POS_W'(hit_idx);
            if (op == OP_DELETE) count <= count - CNT_W'(1);
          end else begin
            res_status <= ST_MISSING;
            res_pos    <= '0;
          end
          state <= S_EMIT;
        end
        S_SORT: begin
          // one odd-even transposition pass per cycle
          if (sort_cnt == IDX_W'(DEPTH - 1)) begin
            sort_cnt   <= '0;
            res_status <= ST_DONE;
            res_pos    <= '0;
            state      <= S_EMIT;
          end else begin
            sort_cnt <= sort_cnt + IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_status   <= res_status;
            rsp_position <= res_pos;
            rsp_count    <= ECNT_W'(count);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.position     = rsp_position;
  assign rsp.entry_count  = rsp_count;

  assign del_hit     = (state == S_PICK) && (op == OP_DELETE) && found;
  assign search_done = (state == S_PICK) && (op == OP_SEARCH);

  `ITSDS_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "entry count beyond depth")
  `ITSDS_ASSERT_NEXT(a_sort_keeps_count, state == S_SORT, count == $past(count), "sort changed count")
  `ITSDS_ASSERT_NEXT(a_delete_shrinks, del_hit, count == $past(count) - CNT_W'(1), "delete kept count")
  `ITSDS_ASSERT_NEXT(a_search_keeps_count, search_done, count == $past(count), "search changed count")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the integer table block: insert, search, delete and sort
// depends on itsds_pkg, itsds_if and integer_table_insert_search_delete_sort_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itsds_pkg::*;

  localparam int DRAIN_CYCLES  = DEPTH + 6;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 160;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [ECNT_W-1:0] entry_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  itsds_req_if req ();
  itsds_rsp_if rsp ();

  integer_table_insert_search_delete_sort_top dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // shadow copy of the table, updated on each accepted request
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int shadow_count;

  table_result_t pending_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int idle_cycles;
  int requests_taken;
  int results_checked;
  int mismatches;
  int full_seen;
  int missing_seen;
  int sorts_seen;

  function automatic table_result_t apply_request(input op_t op,
                                                  input logic signed [DATA_W-1:0] value);
    table_result_t r;
    int hit;
    logic signed [DATA_W-1:0] tmp;
    r.status = ST_DONE;
    r.position = '0;
    hit = -1;
    if (op == OP_SEARCH || op == OP_DELETE) begin
      for (int i = shadow_count - 1; i >= 0; i--) begin
        if (shadow_entries[i] == value) hit = i;
      end
    end
    case (op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = value;
          r.position = shadow_count[POS_W-1:0];
          shadow_count++;
        end
      end
      OP_SEARCH: begin
        if (hit < 0) r.status = ST_MISSING;
        else r.position = hit[POS_W-1:0];
      end
      OP_DELETE: begin
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.position = hit[POS_W-1:0];
          shadow_entries[hit] = shadow_entries[shadow_count - 1];
          shadow_count--;
        end
      end
      default: begin
        for (int i = 0; i + 1 < shadow_count; i++) begin
          for (int j = i + 1; j < shadow_count; j++) begin
            if (shadow_entries[j] < shadow_entries[i]) begin
              tmp = shadow_entries[i];
              shadow_entries[i] = shadow_entries[j];
              shadow_entries[j] = tmp;
            end
          end
        end
      end
    endcase
    r.entry_count = shadow_count[ECNT_W-1:0];
    return r;
  endfunction

  // request side first, so a prediction always precedes its result
  always @(posedge clk) begin
    table_result_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        want = apply_request(op_t'(req.func), req.operand_value);
        pending_results.push_back(want);
        requests_taken++;
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_MISSING) missing_seen++;
        if (op_t'(req.func) == OP_SORT) sorts_seen++;
      end
      if (rsp.valid && rsp.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: status %0d position %0d entry_count %0d",
                 rsp.status, rsp.position, rsp.entry_count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, rsp.position);
            mismatches++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   rsp.entry_count);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES - 1;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_request(input op_t op, input logic signed [DATA_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req.valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.func <= op;
    req.operand_value <= value;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input int hit_pct);
    if (shadow_count > 0 && $urandom_range(99) < hit_pct)
      return shadow_entries[$urandom_range(shadow_count - 1)];
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(7)) - 32'sd4;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 38) send_request(OP_INSERT, pick_value(30));
    else if (pick < 62) send_request(OP_SEARCH, pick_value(65));
    else if (pick < 90) send_request(OP_DELETE, pick_value(65));
    else send_request(OP_SORT, $signed($urandom()));
  endtask

  task automatic test_empty_table();
    send_request(OP_SEARCH, 32'sd5);
    send_request(OP_DELETE, 32'sd5);
    send_request(OP_SORT, 32'sd0);
    wait_for_drain();
  endtask

  task automatic test_extreme_values();
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_SORT, 32'sh1234_5678);     // one entry, nothing moves
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_SEARCH, -32'sd1);          // duplicate, lowest index wins
    send_request(OP_DELETE, -32'sd1);
    send_request(OP_SEARCH, 32'sh8000_0000);
    send_request(OP_SORT, 32'sh0);
    send_request(OP_SEARCH, 32'sh7fff_ffff);
    wait_for_drain();
  endtask

  task automatic test_full_table();
    int fill;
    fill = DEPTH - shadow_count;
    repeat (fill) send_request(OP_INSERT, $signed($urandom()));
    send_request(OP_INSERT, 32'sd42);           // table full
    send_request(OP_SORT, 32'sd0);
    wait_for_drain();
    // largest entry sits at the top index after the sort
    send_request(OP_DELETE, shadow_entries[DEPTH - 1]);
    send_request(OP_SEARCH, shadow_entries[0]);
    wait_for_drain();
  endtask

  task automatic test_random_mix(input int items, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_random_request();
    wait_for_drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (12) send_random_request();
    wait_for_drain();
  endtask

  initial begin
    req.valid = 1'b0;
    req.func = OP_INSERT;
    req.operand_value = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_extreme_values();
    test_full_table();
    test_random_mix(150, 0, 0);
    test_random_mix(150, 52, 0);
    test_output_backpressure();
    test_random_mix(150, 0, 52);
    test_random_mix(150, 6, 6);

    $display("%0d requests, %0d results checked, %0d mismatches", requests_taken,
             results_checked, mismatches);
    $display("table full %0d times, value missing %0d times, %0d sorts", full_seen,
             missing_seen, sorts_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
